@@ rtl/mclk_pkg.sv @@
// Package for the majority-clocked keystream unit: word types, register map
// and the single-bit step of the three shift registers. No dependencies.
package mclk_pkg;

    localparam int unsigned R1_W   = 19;
    localparam int unsigned R2_W   = 22;
    localparam int unsigned R3_W   = 23;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned ADDR_W = 4;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SEED_ONE   = 2'd0;
    localparam logic [1:0] REG_SEED_TWO   = 2'd1;
    localparam logic [1:0] REG_SEED_THREE = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              reload_seed;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        logic [BYTE_W-1:0] keystream_byte;
    } out_word_t;

    typedef struct packed {
        logic [R1_W-1:0] r1;
        logic [R2_W-1:0] r2;
        logic [R3_W-1:0] r3;
    } lfsr_state_t;

    // Keystream bit: XOR of the three top bits before any register moves
    function automatic logic ks_bit(lfsr_state_t s);
        return s.r1[R1_W-1] ^ s.r2[R2_W-1] ^ s.r3[R3_W-1];
    endfunction

    // One majority-clocked step of all three registers
    function automatic lfsr_state_t lfsr_step(lfsr_state_t s);
        logic        c1;
        logic        c2;
        logic        c3;
        logic        maj;
        logic        fb1;
        logic        fb2;
        logic        fb3;
        lfsr_state_t n;
        c1  = s.r1[8];
        c2  = s.r2[10];
        c3  = s.r3[10];
        maj = (c1 & c2) | (c1 & c3) | (c2 & c3);
        fb1 = s.r1[13] ^ s.r1[16] ^ s.r1[17] ^ s.r1[18];
        fb2 = s.r2[20] ^ s.r2[21];
        fb3 = s.r3[7] ^ s.r3[20] ^ s.r3[21] ^ s.r3[22];
        n   = s;
        if (c1 == maj) begin
            n.r1 = {s.r1[R1_W-2:0], fb1};
        end
        if (c2 == maj) begin
            n.r2 = {s.r2[R2_W-2:0], fb2};
        end
        if (c3 == maj) begin
            n.r3 = {s.r3[R3_W-2:0], fb3};
        end
        return n;
    endfunction

endpackage

@@ rtl/majority_clocked_lfsr_keystream_unit.sv @@
// Majority-clocked three-register keystream unit (adapted A5/1) top level.
// Depends on mclk_pkg for word types, register map and the step function.
//
// Takes one data word per cycle while results are taken and returns one result
// word per input. A word accepted at a clock edge is held in an input register;
// when the result register is empty or being taken, the eight clocking steps of
// the 19/22/23-bit shift registers, run as a chain of XOR and majority logic,
// update the cipher state and load the result register, which shows the result
// word. A word can follow in every cycle while results are taken, because the
// whole eight-step chain is combinational and the state is ready for the next
// word at the edge that moves this one; a stalled result word holds the input
// register and then the input side. Seeds are written over the APB port at
// byte addresses 0, 4 and 8, masked to register width; reload_seed copies them
// into the state before its word's keystream is made.
module majority_clocked_lfsr_keystream_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input words
    input  logic                        s_valid,
    output logic                        s_ready,
    input  mclk_pkg::in_word_t          s_word,
    // result words
    output logic                        m_valid,
    input  logic                        m_ready,
    output mclk_pkg::out_word_t         m_word,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mclk_pkg::ADDR_W-1:0] paddr,
    input  logic [mclk_pkg::DATA_W-1:0] pwdata,
    output logic [mclk_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    logic [mclk_pkg::R1_W-1:0] seed_one_reg;
    logic [mclk_pkg::R2_W-1:0] seed_two_reg;
    logic [mclk_pkg::R3_W-1:0] seed_three_reg;
    logic [1:0]                reg_index;
    logic                      cfg_write;

    mclk_pkg::lfsr_state_t     state_reg;
    mclk_pkg::lfsr_state_t     state_next;
    logic                      in_valid_reg;
    mclk_pkg::in_word_t        in_word_reg;
    logic                      out_valid_reg;
    mclk_pkg::out_word_t       out_word_reg;
    mclk_pkg::out_word_t       out_word_next;
    logic                      advance;

    // Configuration port: always ready, write on access phase
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_one_reg   <= '0;
            seed_two_reg   <= '0;
            seed_three_reg <= '0;
        end else if (cfg_write) begin
            unique case (reg_index)
                mclk_pkg::REG_SEED_ONE:   seed_one_reg   <= pwdata[mclk_pkg::R1_W-1:0];
                mclk_pkg::REG_SEED_TWO:   seed_two_reg   <= pwdata[mclk_pkg::R2_W-1:0];
                mclk_pkg::REG_SEED_THREE: seed_three_reg <= pwdata[mclk_pkg::R3_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back seeds, zero-extended
    always_comb begin
        unique case (reg_index)
            mclk_pkg::REG_SEED_ONE:
                prdata = {{(mclk_pkg::DATA_W-mclk_pkg::R1_W){1'b0}}, seed_one_reg};
            mclk_pkg::REG_SEED_TWO:
                prdata = {{(mclk_pkg::DATA_W-mclk_pkg::R2_W){1'b0}}, seed_two_reg};
            mclk_pkg::REG_SEED_THREE:
                prdata = {{(mclk_pkg::DATA_W-mclk_pkg::R3_W){1'b0}}, seed_three_reg};
            default:
                prdata = '0;
        endcase
    end

    // Move a word from the input register into the result register
    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;

    // Run the eight clocking steps, first keystream bit into the MSB
    always_comb begin
        mclk_pkg::lfsr_state_t    st;
        logic [mclk_pkg::BYTE_W-1:0] ks;
        if (in_word_reg.reload_seed) begin
            st = '{r1: seed_one_reg, r2: seed_two_reg, r3: seed_three_reg};
        end else begin
            st = state_reg;
        end
        ks = '0;
        for (int i = 0; i < mclk_pkg::BYTE_W; i++) begin
            ks = {ks[mclk_pkg::BYTE_W-2:0], mclk_pkg::ks_bit(st)};
            st = mclk_pkg::lfsr_step(st);
        end
        state_next                   = st;
        out_word_next.keystream_byte = ks;
        out_word_next.result_byte    = in_word_reg.data_byte ^ ks;
    end

    // Hold control state, advance pipeline and cipher state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
        if (advance) begin
            out_word_reg <= out_word_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_word_reg;

endmodule

@@ rtl/mclk_checker.sv @@
// Port-level checker for the keystream unit, with its bind statement.
// Depends on mclk_pkg for the word types.
module mclk_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input mclk_pkg::out_word_t m_word,
    input logic                pready
);

    // Drop any pending result on reset
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Empty result register never stalls the input side
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Hold a stalled result word
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("stalled result word changed");

    // Configuration port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind majority_clocked_lfsr_keystream_unit mclk_checker u_mclk_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word),
    .pready  (pready)
);

@@ test/testbench.sv @@
// Testbench for majority_clocked_lfsr_keystream_unit: an in-house keystream predictor
// in a small scoreboard class, valid/ready drivers with random gaps, and APB seed writes.
// Depends on mclk_pkg for word types, widths and register indexes.
`timescale 1ns / 1ps

// Predicts the keystream of the three majority-clocked registers and holds expected words
class keystream_board;
    logic [mclk_pkg::R1_W-1:0]   seed_a;
    logic [mclk_pkg::R2_W-1:0]   seed_b;
    logic [mclk_pkg::R3_W-1:0]   seed_c;
    logic [mclk_pkg::R1_W-1:0]   lfsr_a;
    logic [mclk_pkg::R2_W-1:0]   lfsr_b;
    logic [mclk_pkg::R3_W-1:0]   lfsr_c;
    mclk_pkg::out_word_t         expected_q[$];
    int                          fail_count;

    function new();
        seed_a     = '0;
        seed_b     = '0;
        seed_c     = '0;
        lfsr_a     = '0;
        lfsr_b     = '0;
        lfsr_c     = '0;
        fail_count = 0;
    endfunction

    // Keep only the bits that fit the register; unmapped indexes change nothing
    function void write_seed(logic [1:0] idx, logic [mclk_pkg::DATA_W-1:0] value);
        case (idx)
            mclk_pkg::REG_SEED_ONE: begin
                seed_a = value[mclk_pkg::R1_W-1:0];
            end
            mclk_pkg::REG_SEED_TWO: begin
                seed_b = value[mclk_pkg::R2_W-1:0];
            end
            mclk_pkg::REG_SEED_THREE: begin
                seed_c = value[mclk_pkg::R3_W-1:0];
            end
            default: begin
            end
        endcase
    endfunction

    function logic [mclk_pkg::DATA_W-1:0] seed_value(logic [1:0] idx);
        logic [mclk_pkg::DATA_W-1:0] v;
        v = '0;
        case (idx)
            mclk_pkg::REG_SEED_ONE: begin
                v[mclk_pkg::R1_W-1:0] = seed_a;
            end
            mclk_pkg::REG_SEED_TWO: begin
                v[mclk_pkg::R2_W-1:0] = seed_b;
            end
            mclk_pkg::REG_SEED_THREE: begin
                v[mclk_pkg::R3_W-1:0] = seed_c;
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    // One bit step: output from the top bits, then shift the registers that agree
    function logic clock_once();
        logic vote;
        logic bit_out;
        vote    = (lfsr_a[8] & lfsr_b[10]) | (lfsr_a[8] & lfsr_c[10])
                | (lfsr_b[10] & lfsr_c[10]);
        bit_out = lfsr_a[mclk_pkg::R1_W-1] ^ lfsr_b[mclk_pkg::R2_W-1]
                ^ lfsr_c[mclk_pkg::R3_W-1];
        if (lfsr_a[8] == vote) begin
            lfsr_a = {lfsr_a[mclk_pkg::R1_W-2:0],
                      lfsr_a[13] ^ lfsr_a[16] ^ lfsr_a[17] ^ lfsr_a[18]};
        end
        if (lfsr_b[10] == vote) begin
            lfsr_b = {lfsr_b[mclk_pkg::R2_W-2:0], lfsr_b[20] ^ lfsr_b[21]};
        end
        if (lfsr_c[10] == vote) begin
            lfsr_c = {lfsr_c[mclk_pkg::R3_W-2:0],
                      lfsr_c[7] ^ lfsr_c[20] ^ lfsr_c[21] ^ lfsr_c[22]};
        end
        return bit_out;
    endfunction

    // Advance the cipher by one byte and queue the expected result word
    function void note_word(mclk_pkg::in_word_t w);
        logic [mclk_pkg::BYTE_W-1:0] ks;
        mclk_pkg::out_word_t         r;
        if (w.reload_seed) begin
            lfsr_a = seed_a;
            lfsr_b = seed_b;
            lfsr_c = seed_c;
        end
        ks = '0;
        for (int i = 0; i < mclk_pkg::BYTE_W; i++) begin
            ks = {ks[mclk_pkg::BYTE_W-2:0], clock_once()};
        end
        r.result_byte    = w.data_byte ^ ks;
        r.keystream_byte = ks;
        expected_q = {expected_q, r};
    endfunction

    // Compare a result word with the oldest expected one
    function void check_word(mclk_pkg::out_word_t got);
        mclk_pkg::out_word_t want;
        if (expected_q.size() == 0) begin
            $error("unexpected result word %h", got);
            fail_count++;
            return;
        end
        want = expected_q.pop_front();
        if (got.result_byte !== want.result_byte) begin
            $error("result_byte: expected %h, got %h", want.result_byte, got.result_byte);
            fail_count++;
        end
        if (got.keystream_byte !== want.keystream_byte) begin
            $error("keystream_byte: expected %h, got %h",
                   want.keystream_byte, got.keystream_byte);
            fail_count++;
        end
    endfunction
endclass

module testbench;

    localparam int         IDLE_LIMIT   = 3000;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         PHASES       = 8;
    localparam int         PHASE_WORDS  = 210;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    mclk_pkg::in_word_t              s_word;
    logic                            m_valid;
    logic                            m_ready;
    mclk_pkg::out_word_t             m_word;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [mclk_pkg::ADDR_W-1:0]     paddr;
    logic [mclk_pkg::DATA_W-1:0]     pwdata;
    logic [mclk_pkg::DATA_W-1:0]     prdata;
    logic                            pready;

    keystream_board        board;
    bit                    calm;
    bit                    sink_hold_req;
    bit                    sink_holding;
    int                    idle_cycles;

    majority_clocked_lfsr_keystream_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Clock
    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic mclk_pkg::in_word_t make_word(logic [mclk_pkg::BYTE_W-1:0] data,
                                                     logic reload);
        mclk_pkg::in_word_t w;
        w.data_byte   = data;
        w.reload_seed = reload;
        return w;
    endfunction

    // Offer one word, hold it until accepted, then idle for gap cycles
    task automatic push_word(input mclk_pkg::in_word_t w, input int gap);
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        board.note_word(w);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    function automatic int sender_gap();
        if (calm || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return pick_gap();
    endfunction

    // Drop valid and wait until every expected word has come back
    task automatic settle_block();
        s_valid <= 1'b0;
        while (board.expected_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    // One APB transfer: setup cycle, access cycle, then release
    task automatic apb_xfer(input logic wr, input logic [1:0] idx,
                            input logic [mclk_pkg::DATA_W-1:0] wdata,
                            output logic [mclk_pkg::DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        rdata = prdata;
        if (wr) begin
            board.write_seed(idx, wdata);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // Write a seed register and read it back where it is mapped
    task automatic write_seed(input logic [1:0] idx, input logic [mclk_pkg::DATA_W-1:0] value);
        logic [mclk_pkg::DATA_W-1:0] rd;
        apb_xfer(1'b1, idx, value, rd);
        if (idx != REG_UNMAPPED) begin
            apb_xfer(1'b0, idx, '0, rd);
            if (rd !== board.seed_value(idx)) begin
                $error("prdata: expected %h, got %h", board.seed_value(idx), rd);
                board.fail_count++;
            end
        end
    endtask

    function automatic logic [mclk_pkg::DATA_W-1:0] pick_seed(int unsigned width);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom();
            3: return (32'd1 << width) - 1;
            default: return $urandom_range(0, (32'd1 << width) - 1);
        endcase
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                sink_holding  = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                sink_holding  = 1'b0;
            end else if (!calm && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat (pick_gap()) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge aclk);
        end
    end

    // Check result words and watch for a stuck block
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_word(m_word);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin
        board         = new();
        calm          = 1'b0;
        sink_hold_req = 1'b0;
        sink_holding  = 1'b0;
        idle_cycles   = 0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_word        = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // All-zero state gives a zero keystream, with and without reload
        push_word(make_word(8'h00, 1'b0), sender_gap());
        push_word(make_word(8'hFF, 1'b1), sender_gap());
        push_word(make_word(8'h5A, 1'b0), sender_gap());

        // Wide seed values get masked; an unmapped index is ignored
        settle_block();
        write_seed(mclk_pkg::REG_SEED_ONE, 32'hFFFF_FFFF);
        write_seed(mclk_pkg::REG_SEED_TWO, 32'hFFFF_FFFF);
        write_seed(mclk_pkg::REG_SEED_THREE, 32'hFFFF_FFFF);
        write_seed(REG_UNMAPPED, 32'h1234_5678);
        push_word(make_word(8'h00, 1'b1), sender_gap());
        push_word(make_word(8'hFF, 1'b0), sender_gap());
        push_word(make_word(8'hA5, 1'b0), sender_gap());
        push_word(make_word(8'h5A, 1'b0), sender_gap());
        push_word(make_word(8'hFF, 1'b0), sender_gap());

        // Only the top bit of each register set
        settle_block();
        write_seed(mclk_pkg::REG_SEED_ONE, 32'd1 << (mclk_pkg::R1_W - 1));
        write_seed(mclk_pkg::REG_SEED_TWO, 32'd1 << (mclk_pkg::R2_W - 1));
        write_seed(mclk_pkg::REG_SEED_THREE, 32'd1 << (mclk_pkg::R3_W - 1));
        push_word(make_word(8'h00, 1'b1), sender_gap());
        push_word(make_word(8'hFF, 1'b0), sender_gap());
        push_word(make_word(8'h80, 1'b0), sender_gap());
        push_word(make_word(8'h01, 1'b0), sender_gap());

        // Mixed extremes: empty, full, and a lone clocking bit
        settle_block();
        write_seed(mclk_pkg::REG_SEED_ONE, 32'h0);
        write_seed(mclk_pkg::REG_SEED_TWO, 32'h003F_FFFF);
        write_seed(mclk_pkg::REG_SEED_THREE, 32'd1 << 10);
        push_word(make_word(8'hAA, 1'b1), sender_gap());
        push_word(make_word(8'h55, 1'b0), sender_gap());
        push_word(make_word(8'hFF, 1'b1), sender_gap());
        push_word(make_word(8'h00, 1'b0), sender_gap());

        // Random phases: new seeds, then messages that start with a reload
        for (int p = 0; p < PHASES; p++) begin
            int burst_left;
            settle_block();
            calm = (p == 2 || p == 6);
            write_seed(mclk_pkg::REG_SEED_ONE, pick_seed(mclk_pkg::R1_W));
            write_seed(mclk_pkg::REG_SEED_TWO, pick_seed(mclk_pkg::R2_W));
            write_seed(mclk_pkg::REG_SEED_THREE, pick_seed(mclk_pkg::R3_W));
            if ($urandom_range(0, 3) == 0) begin
                write_seed(REG_UNMAPPED, $urandom());
            end
            burst_left = 0;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                logic reload;
                int   gap;
                if (p == 3 && n == 100) begin
                    // Stall the receiver for a long time and keep offering words
                    s_valid <= 1'b0;
                    sink_hold_req = 1'b1;
                    wait (sink_holding);
                    @(negedge aclk);
                    burst_left = 40;
                end
                if (p == 5 && n == 100) begin
                    settle_block();
                end
                reload = (n == 0) || ($urandom_range(0, 15) == 0);
                gap    = (burst_left > 0) ? 0 : sender_gap();
                if (burst_left > 0) begin
                    burst_left--;
                end
                push_word(make_word(mclk_pkg::BYTE_W'($urandom_range(0, 255)), reload), gap);
            end
        end
        calm = 1'b0;

        // Drain and give the block time to show any stray word
        s_valid <= 1'b0;
        while (board.expected_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (board.fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ majority_clocked_lfsr_keystream_unit.f @@
rtl/mclk_pkg.sv
rtl/majority_clocked_lfsr_keystream_unit.sv
rtl/mclk_checker.sv
test/testbench.sv
